// File: rtl/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// Types and constants shared by the RTT estimator pipeline: request and
// result payloads, inter-stage payloads, register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rte_pkg;

  // register map, index = byte address / 4
  localparam int unsigned RegIdxW = 2;
  localparam logic [RegIdxW-1:0] REG_MAX_ACK_DELAY     = 2'd0;
  localparam logic [RegIdxW-1:0] REG_TIMER_GRANULARITY = 2'd1;
  localparam logic [RegIdxW-1:0] REG_INITIAL_TIMEOUT   = 2'd2;
  localparam int unsigned AddrW = RegIdxW + 2;

  // register reset values
  localparam logic [31:0] RST_MAX_ACK_DELAY     = 32'd0;
  localparam logic [31:0] RST_TIMER_GRANULARITY = 32'd1000;
  localparam logic [31:0] RST_INITIAL_TIMEOUT   = 32'd200000;

  // request payload
  typedef struct packed {
    logic [31:0] rtt_sample;
    logic [31:0] ack_delay;
    logic        include_ack_delay;
  } in_t;

  // result payload
  typedef struct packed {
    logic        rejected;
    logic [31:0] latest_rtt;
    logic [31:0] min_rtt;
    logic [31:0] smoothed_rtt;
    logic [31:0] rtt_variation;
    logic [34:0] probe_timeout;
  } out_t;

  // after min / latest update
  typedef struct packed {
    logic        rejected;
    logic        include_ack_delay;
    logic [31:0] latest_rtt;
    logic [31:0] min_rtt;
  } mid_t;

  // after smoothing update
  typedef struct packed {
    logic        rejected;
    logic        include_ack_delay;
    logic [31:0] latest_rtt;
    logic [31:0] min_rtt;
    logic [31:0] smoothed_rtt;
    logic [31:0] rtt_variation;
  } ewma_t;

  // configuration registers
  typedef struct packed {
    logic [31:0] max_ack_delay;
    logic [31:0] timer_granularity;
    logic [31:0] initial_timeout;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/rte_min_stage.sv
// ----------------------------------------------------------------------------
// rte_min_stage
// Input register plus minimum RTT tracking and ack delay adjustment. Holds
// the min and latest RTT state; a zero sample leaves both untouched.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_min_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rte_pkg::in_t  in_data,
  output logic               mid_valid,
  input  wire logic          mid_ready,
  output rte_pkg::mid_t      mid_data
);
  import rte_pkg::*;

  logic        in_valid_r;
  in_t         in_r;
  logic        mid_valid_r;
  mid_t        mid_r;
  logic [31:0] min_r;
  logic [31:0] latest_r;

  logic        fwd_ok;
  logic        move;
  logic        rej;
  logic [31:0] min_nxt;
  logic [31:0] latest_nxt;
  mid_t        mid_nxt;

  // flow control
  assign fwd_ok   = !mid_valid_r || mid_ready;
  assign move     = in_valid_r && fwd_ok;
  assign in_ready = !in_valid_r || fwd_ok;

  // min tracking and ack delay subtraction against the new minimum
  always_comb begin
    rej     = (in_r.rtt_sample == 32'd0);
    min_nxt = min_r;
    if (min_r == 32'd0 || min_r > in_r.rtt_sample) begin
      min_nxt = in_r.rtt_sample;
    end
    latest_nxt = in_r.rtt_sample;
    if ((in_r.rtt_sample - min_nxt) >= in_r.ack_delay) begin
      latest_nxt = in_r.rtt_sample - in_r.ack_delay;
    end
    mid_nxt.rejected          = rej;
    mid_nxt.include_ack_delay = in_r.include_ack_delay;
    mid_nxt.latest_rtt        = rej ? latest_r : latest_nxt;
    mid_nxt.min_rtt           = rej ? min_r : min_nxt;
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      mid_valid_r <= 1'b0;
      min_r       <= 32'd0;
      latest_r    <= 32'd0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (fwd_ok) begin
        mid_valid_r <= in_valid_r;
      end
      if (move && !rej) begin
        min_r    <= min_nxt;
        latest_r <= latest_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (move) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_valid = mid_valid_r;
  assign mid_data  = mid_r;

  // once a sample was taken the minimum never returns to zero
  a_min_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (min_r != 32'd0) |=> (min_r != 32'd0))
    else $error("min rtt dropped back to zero");

  // adjusted sample never falls below the minimum
  a_latest_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
    latest_r >= min_r)
    else $error("latest rtt below min rtt");

  // a rejected request leaves the state alone
  a_rej_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (move && rej) |=> ($stable(min_r) && $stable(latest_r)))
    else $error("rejected sample changed state");

endmodule

`default_nettype wire

// File: rtl/rte_ewma_stage.sv
// ----------------------------------------------------------------------------
// rte_ewma_stage
// Smoothed RTT and RTT variation update with exact floor arithmetic. The
// first accepted sample seeds both values; later ones average them in.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_ewma_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          mid_valid,
  output logic               mid_ready,
  input  wire rte_pkg::mid_t mid_data,
  output logic               ewma_valid,
  input  wire logic          ewma_ready,
  output rte_pkg::ewma_t     ewma_data
);
  import rte_pkg::*;

  logic        ewma_valid_r;
  ewma_t       ewma_r;
  logic [31:0] smooth_r;
  logic [31:0] var_r;

  logic        move;
  logic [31:0] x;
  logic [31:0] diff;
  logic [33:0] var3;
  logic [34:0] nv_sum;
  logic [34:0] smooth7;
  logic [35:0] ns_sum;
  logic [31:0] smooth_nxt;
  logic [31:0] var_nxt;
  ewma_t       ewma_nxt;

  // flow control
  assign mid_ready = !ewma_valid_r || ewma_ready;
  assign move      = mid_valid && mid_ready;

  // 3/4 var + 1/4 |smooth - x| and 7/8 smooth + 1/8 x
  always_comb begin
    x       = mid_data.latest_rtt;
    diff    = (smooth_r >= x) ? (smooth_r - x) : (x - smooth_r);
    var3    = {2'b00, var_r} + {1'b0, var_r, 1'b0};
    nv_sum  = {1'b0, var3} + {3'b000, diff};
    smooth7 = {smooth_r, 3'b000} - {3'b000, smooth_r};
    ns_sum  = {1'b0, smooth7} + {4'b0000, x};
    if (smooth_r == 32'd0) begin
      smooth_nxt = x;
      var_nxt    = {1'b0, x[31:1]};
    end else begin
      smooth_nxt = ns_sum[34:3];
      var_nxt    = nv_sum[33:2];
    end
    ewma_nxt.rejected          = mid_data.rejected;
    ewma_nxt.include_ack_delay = mid_data.include_ack_delay;
    ewma_nxt.latest_rtt        = mid_data.latest_rtt;
    ewma_nxt.min_rtt           = mid_data.min_rtt;
    ewma_nxt.smoothed_rtt      = mid_data.rejected ? smooth_r : smooth_nxt;
    ewma_nxt.rtt_variation     = mid_data.rejected ? var_r : var_nxt;
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ewma_valid_r <= 1'b0;
      smooth_r     <= 32'd0;
      var_r        <= 32'd0;
    end else begin
      if (mid_ready) begin
        ewma_valid_r <= mid_valid;
      end
      if (move && !mid_data.rejected) begin
        smooth_r <= smooth_nxt;
        var_r    <= var_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (move) begin
      ewma_r <= ewma_nxt;
    end
  end

  assign ewma_valid = ewma_valid_r;
  assign ewma_data  = ewma_r;

  // smoothed rtt stays nonzero once seeded
  a_smooth_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (smooth_r != 32'd0) |=> (smooth_r != 32'd0))
    else $error("smoothed rtt dropped back to zero");

  // an accepted sample always leaves a seeded estimate behind
  a_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    (move && !mid_data.rejected) |=> (smooth_r != 32'd0 && ewma_r.smoothed_rtt == smooth_r))
    else $error("accepted sample did not seed smoothed rtt");

  // a rejected request leaves the estimate alone
  a_rej_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (move && mid_data.rejected) |=> ($stable(smooth_r) && $stable(var_r)))
    else $error("rejected sample changed smoothed state");

endmodule

`default_nettype wire

// File: rtl/rte_pto_stage.sv
// ----------------------------------------------------------------------------
// rte_pto_stage
// Probe timeout from the updated estimate and the result register that
// drives the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_pto_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rte_pkg::cfg_t  cfg,
  input  wire logic           ewma_valid,
  output logic                ewma_ready,
  input  wire rte_pkg::ewma_t ewma_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rte_pkg::out_t       out_data
);
  import rte_pkg::*;

  logic        out_valid_r;
  out_t        out_r;

  logic        move;
  logic [33:0] four_var;
  logic [33:0] var_term;
  logic [34:0] base_sum;
  logic [34:0] pto;
  out_t        out_nxt;

  // flow control
  assign ewma_ready = !out_valid_r || out_ready;
  assign move       = ewma_valid && ewma_ready;

  // initial timeout while unseeded, else smoothed + max(4*var, granularity) [+ max ack delay]
  always_comb begin
    four_var = {ewma_data.rtt_variation, 2'b00};
    var_term = (four_var < {2'b00, cfg.timer_granularity}) ?
               {2'b00, cfg.timer_granularity} : four_var;
    base_sum = {3'b000, ewma_data.smoothed_rtt} + {1'b0, var_term};
    if (ewma_data.smoothed_rtt == 32'd0) begin
      pto = {3'b000, cfg.initial_timeout};
    end else if (ewma_data.include_ack_delay) begin
      pto = base_sum + {3'b000, cfg.max_ack_delay};
    end else begin
      pto = base_sum;
    end
    out_nxt.rejected      = ewma_data.rejected;
    out_nxt.latest_rtt    = ewma_data.latest_rtt;
    out_nxt.min_rtt       = ewma_data.min_rtt;
    out_nxt.smoothed_rtt  = ewma_data.smoothed_rtt;
    out_nxt.rtt_variation = ewma_data.rtt_variation;
    out_nxt.probe_timeout = pto;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ewma_ready) begin
      out_valid_r <= ewma_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: rtl/rtt_estimator_with_pto.sv
// ----------------------------------------------------------------------------
// rtt_estimator_with_pto
// QUIC style RTT estimator with probe timeout.
//
// Requests arrive on the in_ channel (valid/ready) carrying an RTT sample,
// the peer ack delay and a flag that adds max_ack_delay to the timeout.
// Every request yields exactly one result on the out_ channel: a reject
// flag (zero sample), latest, min and smoothed RTT, variation and the
// probe timeout computed from the updated state.
// The datapath is a four-register pipeline: input register, min/latest
// update, smoothing update, timeout and result register. One request per
// cycle is sustained while out_ready stays high; each estimator
// register is updated by its own stage as the request passes, so
// back-to-back requests see the previous update.
// When out_ready is low the result register holds and the stages behind
// it keep filling, so up to four requests are taken before in_ready drops.
// Reset clears the estimate (no sample yet), the pipeline and the config
// registers to their defaults. The APB-style port holds max_ack_delay at
// 0x0, timer_granularity at 0x4 and initial_timeout at 0x8; write it only
// while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_estimator_with_pto (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire rte_pkg::in_t            in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output rte_pkg::out_t                out_data,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [rte_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rte_pkg::*;

  cfg_t               cfg_r;
  logic [RegIdxW-1:0] reg_idx;
  logic               cfg_wr;

  logic  mid_valid;
  logic  mid_ready;
  mid_t  mid_data;
  logic  ewma_valid;
  logic  ewma_ready;
  ewma_t ewma_data;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_ack_delay     <= RST_MAX_ACK_DELAY;
      cfg_r.timer_granularity <= RST_TIMER_GRANULARITY;
      cfg_r.initial_timeout   <= RST_INITIAL_TIMEOUT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MAX_ACK_DELAY:     cfg_r.max_ack_delay     <= pwdata;
        REG_TIMER_GRANULARITY: cfg_r.timer_granularity <= pwdata;
        REG_INITIAL_TIMEOUT:   cfg_r.initial_timeout   <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_MAX_ACK_DELAY:     prdata = cfg_r.max_ack_delay;
      REG_TIMER_GRANULARITY: prdata = cfg_r.timer_granularity;
      REG_INITIAL_TIMEOUT:   prdata = cfg_r.initial_timeout;
      default:               prdata = 32'd0;
    endcase
  end

  // pipeline
  rte_min_stage u_min (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_data  (mid_data)
  );

  rte_ewma_stage u_ewma (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid_data   (mid_data),
    .ewma_valid (ewma_valid),
    .ewma_ready (ewma_ready),
    .ewma_data  (ewma_data)
  );

  rte_pto_stage u_pto (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .ewma_valid (ewma_valid),
    .ewma_ready (ewma_ready),
    .ewma_data  (ewma_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
